>>> sv/cfm_pkg.sv
// Shared types, constants and functions of the complex floating-point multiplier.
`default_nettype none

package cfm_pkg;

    // Register stages of one multiplier, of one adder, and of the whole complex core.
    localparam int unsigned MUL_LAT  = 8;
    localparam int unsigned ADD_LAT  = 7;
    localparam int unsigned CORE_LAT = MUL_LAT + ADD_LAT;

    localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] POS_INF   = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] ONE       = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] ZERO      = 64'h0000_0000_0000_0000;

    localparam logic signed [12:0] BIAS    = 13'sd1023;
    localparam logic signed [12:0] EXP_TOP = 13'sd2046;

    typedef enum logic [1:0] {
        FC_NORM,
        FC_ZERO,
        FC_INF,
        FC_NAN
    } t_fcls;

    // Unrounded result: value = sig * 2^(expo - 1078), sig[55] is the leading bit
    // of a normal number and sig[0] collects the sticky bits.
    typedef struct packed {
        t_fcls              cls;
        logic               sign;
        logic signed [12:0] expo;
        logic [55:0]        sig;
    } t_unr;

    function automatic logic f_is_nan(input logic [63:0] v);
        return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
    endfunction

    function automatic logic f_is_inf(input logic [63:0] v);
        return (v[62:52] == 11'h7FF) && (v[51:0] == 52'd0);
    endfunction

    function automatic logic f_is_zero(input logic [63:0] v);
        return v[62:0] == 63'd0;
    endfunction

    // Leading zero count of a 64-bit word, 64 for an all-zero word.
    function automatic logic [6:0] f_lzc64(input logic [63:0] v);
        logic [6:0] n;
        logic       found;
        n     = 7'd64;
        found = 1'b0;
        for (int i = 63; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 7'(63 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Right shift that ORs every bit shifted out into the lowest bit.
    function automatic logic [55:0] f_shr_jam(input logic [55:0] v, input logic [11:0] sh);
        logic [55:0] lost_mask;
        logic [55:0] r;
        lost_mask = '0;
        if (sh > 12'd55) begin
            r = {55'd0, |v};
        end else begin
            lost_mask = ~({56{1'b1}} << sh[5:0]);
            r         = (v >> sh[5:0]) | {55'd0, |(v & lost_mask)};
        end
        return r;
    endfunction

    // Moves a result below the normal range to the subnormal exponent.
    function automatic t_unr f_denorm(input t_unr u);
        t_unr               r;
        logic signed [12:0] sh;
        r  = u;
        sh = 13'sd1 - u.expo;
        if (u.cls == FC_NORM && u.expo < 13'sd1) begin
            r.expo = 13'sd1;
            r.sig  = f_shr_jam(u.sig, sh[11:0]);
        end
        return r;
    endfunction

    // Round to nearest even and pack to binary64; NaN comes out canonical.
    function automatic logic [63:0] f_round(input t_unr u);
        logic [52:0]        mant;
        logic               up;
        logic [53:0]        m2;
        logic [52:0]        mf;
        logic signed [12:0] e;
        logic [63:0]        r;
        mant = u.sig[55:3];
        up   = u.sig[2] & (u.sig[1] | u.sig[0] | mant[0]);
        m2   = {1'b0, mant} + {53'd0, up};
        if (m2[53]) begin
            mf = m2[53:1];
            e  = u.expo + 13'sd1;
        end else begin
            mf = m2[52:0];
            e  = u.expo;
        end
        case (u.cls)
            FC_NAN:  r = CANON_NAN;
            FC_INF:  r = {u.sign, POS_INF[62:0]};
            FC_ZERO: r = {u.sign, 63'd0};
            default: begin
                if (e > EXP_TOP) begin
                    r = {u.sign, POS_INF[62:0]};
                end else begin
                    r = {u.sign, (mf[52] ? e[10:0] : 11'd0), mf[51:0]};
                end
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/cfm_fmul.sv
// Pipelined binary64 multiplier with round to nearest even and subnormal support.
`default_nettype none

module cfm_fmul (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);

    // Stage 1: unpack and count leading zeros of subnormal significands.
    cfm_pkg::t_fcls     n_s1_cls, r_s1_cls;
    logic               n_s1_sign, r_s1_sign;
    logic [52:0]        n_s1_ma, n_s1_mb, r_s1_ma, r_s1_mb;
    logic [10:0]        n_s1_ea, n_s1_eb, r_s1_ea, r_s1_eb;
    logic [5:0]         n_s1_lza, n_s1_lzb, r_s1_lza, r_s1_lzb;
    logic [6:0]         lz_a, lz_b;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    // Stage 2: normalized significands.
    cfm_pkg::t_fcls     r_s2_cls;
    logic               r_s2_sign;
    logic [52:0]        n_s2_ma, n_s2_mb, r_s2_ma, r_s2_mb;
    logic signed [12:0] n_s2_ea, n_s2_eb, r_s2_ea, r_s2_eb;

    // Stage 3: four partial products.
    cfm_pkg::t_fcls     r_s3_cls;
    logic               r_s3_sign;
    logic [53:0]        n_s3_hh, r_s3_hh;
    logic [52:0]        n_s3_hl, n_s3_lh, r_s3_hl, r_s3_lh;
    logic [51:0]        n_s3_ll, r_s3_ll;
    logic signed [12:0] n_s3_e, r_s3_e;

    // Stage 4 and 5: partial product summation.
    cfm_pkg::t_fcls     r_s4_cls, r_s5_cls;
    logic               r_s4_sign, r_s5_sign;
    logic [53:0]        n_s4_mid, r_s4_mid, r_s4_hh;
    logic [51:0]        r_s4_ll;
    logic signed [12:0] r_s4_e, r_s5_e;
    logic [105:0]       n_s5_p, r_s5_p;

    // Stages 6 to 8: normalize, denormalize, round.
    cfm_pkg::t_unr      n_s6, r_s6, n_s7, r_s7;
    logic [63:0]        n_s8, r_s8;

    always_comb begin
        a_nan  = cfm_pkg::f_is_nan(i_a);
        b_nan  = cfm_pkg::f_is_nan(i_b);
        a_inf  = cfm_pkg::f_is_inf(i_a);
        b_inf  = cfm_pkg::f_is_inf(i_b);
        a_zero = cfm_pkg::f_is_zero(i_a);
        b_zero = cfm_pkg::f_is_zero(i_b);
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            n_s1_cls = cfm_pkg::FC_NAN;
        end else if (a_inf || b_inf) begin
            n_s1_cls = cfm_pkg::FC_INF;
        end else if (a_zero || b_zero) begin
            n_s1_cls = cfm_pkg::FC_ZERO;
        end else begin
            n_s1_cls = cfm_pkg::FC_NORM;
        end
        n_s1_sign = i_a[63] ^ i_b[63];
        n_s1_ma   = {i_a[62:52] != 11'd0, i_a[51:0]};
        n_s1_mb   = {i_b[62:52] != 11'd0, i_b[51:0]};
        n_s1_ea   = (i_a[62:52] == 11'd0) ? 11'd1 : i_a[62:52];
        n_s1_eb   = (i_b[62:52] == 11'd0) ? 11'd1 : i_b[62:52];
        lz_a      = cfm_pkg::f_lzc64({n_s1_ma, 11'd0});
        lz_b      = cfm_pkg::f_lzc64({n_s1_mb, 11'd0});
        n_s1_lza  = lz_a[5:0];
        n_s1_lzb  = lz_b[5:0];
    end

    always_comb begin
        n_s2_ma = r_s1_ma << r_s1_lza;
        n_s2_mb = r_s1_mb << r_s1_lzb;
        n_s2_ea = $signed({2'b00, r_s1_ea}) - $signed({7'd0, r_s1_lza});
        n_s2_eb = $signed({2'b00, r_s1_eb}) - $signed({7'd0, r_s1_lzb});
    end

    // Each significand splits into a 27-bit high and a 26-bit low half.
    always_comb begin
        n_s3_hh = 54'(r_s2_ma[52:26]) * 54'(r_s2_mb[52:26]);
        n_s3_hl = 53'(r_s2_ma[52:26]) * 53'(r_s2_mb[25:0]);
        n_s3_lh = 53'(r_s2_ma[25:0]) * 53'(r_s2_mb[52:26]);
        n_s3_ll = 52'(r_s2_ma[25:0]) * 52'(r_s2_mb[25:0]);
        n_s3_e  = r_s2_ea + r_s2_eb - cfm_pkg::BIAS;
    end

    always_comb begin
        n_s4_mid = {1'b0, r_s3_hl} + {1'b0, r_s3_lh};
        n_s5_p   = {r_s4_hh, 52'd0} + {26'd0, r_s4_mid, 26'd0} + {54'd0, r_s4_ll};
    end

    always_comb begin
        n_s6.cls  = r_s5_cls;
        n_s6.sign = r_s5_sign;
        if (r_s5_p[105]) begin
            n_s6.sig  = {r_s5_p[105:51], |r_s5_p[50:0]};
            n_s6.expo = r_s5_e + 13'sd1;
        end else begin
            n_s6.sig  = {r_s5_p[104:50], |r_s5_p[49:0]};
            n_s6.expo = r_s5_e;
        end
        n_s7 = cfm_pkg::f_denorm(r_s6);
        n_s8 = cfm_pkg::f_round(r_s7);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_cls  <= n_s1_cls;
            r_s1_sign <= n_s1_sign;
            r_s1_ma   <= n_s1_ma;
            r_s1_mb   <= n_s1_mb;
            r_s1_ea   <= n_s1_ea;
            r_s1_eb   <= n_s1_eb;
            r_s1_lza  <= n_s1_lza;
            r_s1_lzb  <= n_s1_lzb;
            r_s2_cls  <= r_s1_cls;
            r_s2_sign <= r_s1_sign;
            r_s2_ma   <= n_s2_ma;
            r_s2_mb   <= n_s2_mb;
            r_s2_ea   <= n_s2_ea;
            r_s2_eb   <= n_s2_eb;
            r_s3_cls  <= r_s2_cls;
            r_s3_sign <= r_s2_sign;
            r_s3_hh   <= n_s3_hh;
            r_s3_hl   <= n_s3_hl;
            r_s3_lh   <= n_s3_lh;
            r_s3_ll   <= n_s3_ll;
            r_s3_e    <= n_s3_e;
            r_s4_cls  <= r_s3_cls;
            r_s4_sign <= r_s3_sign;
            r_s4_hh   <= r_s3_hh;
            r_s4_mid  <= n_s4_mid;
            r_s4_ll   <= r_s3_ll;
            r_s4_e    <= r_s3_e;
            r_s5_cls  <= r_s4_cls;
            r_s5_sign <= r_s4_sign;
            r_s5_p    <= n_s5_p;
            r_s5_e    <= r_s4_e;
            r_s6      <= n_s6;
            r_s7      <= n_s7;
            r_s8      <= n_s8;
        end
    end

    assign o_p = r_s8;

endmodule

`default_nettype wire

>>> sv/cfm_fadd.sv
// Pipelined binary64 adder with round to nearest even and subnormal support.
`default_nettype none

module cfm_fadd (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_s
);

    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big;
    logic [63:0]        big, sml;

    // Stage 1: order by magnitude, classify.
    cfm_pkg::t_fcls     n_s1_cls, r_s1_cls;
    logic               n_s1_sign, r_s1_sign, n_s1_sub, r_s1_sub;
    logic [10:0]        n_s1_e, r_s1_e, n_s1_d, r_s1_d, es;
    logic [52:0]        n_s1_mb, n_s1_ms, r_s1_mb, r_s1_ms;

    // Stage 2: alignment.
    cfm_pkg::t_fcls     r_s2_cls;
    logic               r_s2_sign, r_s2_sub;
    logic [10:0]        r_s2_e;
    logic [55:0]        n_s2_al, r_s2_al, r_s2_big;

    // Stage 3: add or subtract.
    cfm_pkg::t_fcls     r_s3_cls;
    logic               r_s3_sign;
    logic [10:0]        r_s3_e;
    logic [56:0]        n_s3_sum, r_s3_sum;

    // Stage 4: leading zero count.
    cfm_pkg::t_fcls     r_s4_cls;
    logic               r_s4_sign;
    logic [10:0]        r_s4_e;
    logic [56:0]        r_s4_sum;
    logic [6:0]         lz_full;
    logic [5:0]         n_s4_lz, r_s4_lz;

    // Stages 5 to 7: normalize, denormalize, round.
    cfm_pkg::t_unr      n_s5, r_s5, n_s6, r_s6;
    logic [63:0]        n_s7, r_s7;

    always_comb begin
        a_nan  = cfm_pkg::f_is_nan(i_a);
        b_nan  = cfm_pkg::f_is_nan(i_b);
        a_inf  = cfm_pkg::f_is_inf(i_a);
        b_inf  = cfm_pkg::f_is_inf(i_b);
        a_zero = cfm_pkg::f_is_zero(i_a);
        b_zero = cfm_pkg::f_is_zero(i_b);
        a_big  = i_a[62:0] >= i_b[62:0];
        big    = a_big ? i_a : i_b;
        sml    = a_big ? i_b : i_a;
        n_s1_sign = big[63];
        if (a_nan || b_nan || (a_inf && b_inf && (i_a[63] ^ i_b[63]))) begin
            n_s1_cls = cfm_pkg::FC_NAN;
        end else if (a_inf || b_inf) begin
            n_s1_cls = cfm_pkg::FC_INF;
        end else if (a_zero && b_zero) begin
            n_s1_cls  = cfm_pkg::FC_ZERO;
            n_s1_sign = i_a[63] & i_b[63];
        end else begin
            n_s1_cls = cfm_pkg::FC_NORM;
        end
        n_s1_sub = i_a[63] ^ i_b[63];
        n_s1_e   = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
        es       = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
        n_s1_d   = n_s1_e - es;
        n_s1_mb  = {big[62:52] != 11'd0, big[51:0]};
        n_s1_ms  = {sml[62:52] != 11'd0, sml[51:0]};
    end

    always_comb begin
        n_s2_al  = cfm_pkg::f_shr_jam({r_s1_ms, 3'b000}, {1'b0, r_s1_d});
        n_s3_sum = r_s2_sub ? ({1'b0, r_s2_big} - {1'b0, r_s2_al})
                            : ({1'b0, r_s2_big} + {1'b0, r_s2_al});
        lz_full  = cfm_pkg::f_lzc64({r_s3_sum[55:0], 8'd0});
        n_s4_lz  = lz_full[5:0];
    end

    always_comb begin
        n_s5.cls  = r_s4_cls;
        n_s5.sign = r_s4_sign;
        n_s5.expo = $signed({2'b00, r_s4_e});
        n_s5.sig  = r_s4_sum[55:0];
        if (r_s4_cls == cfm_pkg::FC_NORM) begin
            if (r_s4_sum == 57'd0) begin
                // Exact cancellation gives plus zero.
                n_s5.cls  = cfm_pkg::FC_ZERO;
                n_s5.sign = 1'b0;
            end else if (r_s4_sum[56]) begin
                n_s5.sig  = {r_s4_sum[56:2], r_s4_sum[1] | r_s4_sum[0]};
                n_s5.expo = $signed({2'b00, r_s4_e}) + 13'sd1;
            end else begin
                n_s5.sig  = r_s4_sum[55:0] << r_s4_lz;
                n_s5.expo = $signed({2'b00, r_s4_e}) - $signed({7'd0, r_s4_lz});
            end
        end
        n_s6 = cfm_pkg::f_denorm(r_s5);
        n_s7 = cfm_pkg::f_round(r_s6);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_cls  <= n_s1_cls;
            r_s1_sign <= n_s1_sign;
            r_s1_sub  <= n_s1_sub;
            r_s1_e    <= n_s1_e;
            r_s1_d    <= n_s1_d;
            r_s1_mb   <= n_s1_mb;
            r_s1_ms   <= n_s1_ms;
            r_s2_cls  <= r_s1_cls;
            r_s2_sign <= r_s1_sign;
            r_s2_sub  <= r_s1_sub;
            r_s2_e    <= r_s1_e;
            r_s2_big  <= {r_s1_mb, 3'b000};
            r_s2_al   <= n_s2_al;
            r_s3_cls  <= r_s2_cls;
            r_s3_sign <= r_s2_sign;
            r_s3_e    <= r_s2_e;
            r_s3_sum  <= n_s3_sum;
            r_s4_cls  <= r_s3_cls;
            r_s4_sign <= r_s3_sign;
            r_s4_e    <= r_s3_e;
            r_s4_sum  <= r_s3_sum;
            r_s4_lz   <= n_s4_lz;
            r_s5      <= n_s5;
            r_s6      <= n_s6;
            r_s7      <= n_s7;
        end
    end

    assign o_s = r_s7;

endmodule

`default_nettype wire

>>> sv/cfm_core.sv
// Complex product core: four multipliers feeding a subtractor and an adder.
`default_nettype none

module cfm_core (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic [63:0] i_c,
    input  logic [63:0] i_d,
    output logic [63:0] o_real,
    output logic [63:0] o_imag,
    output logic        o_pp_inf
);

    logic [63:0] ac, bd, ad, bc, neg_bd;
    logic        pp_inf;
    logic        r_pp_inf [cfm_pkg::ADD_LAT];

    cfm_fmul u_mul_ac (.i_clk(i_clk), .i_en(i_en), .i_a(i_a), .i_b(i_c), .o_p(ac));
    cfm_fmul u_mul_bd (.i_clk(i_clk), .i_en(i_en), .i_a(i_b), .i_b(i_d), .o_p(bd));
    cfm_fmul u_mul_ad (.i_clk(i_clk), .i_en(i_en), .i_a(i_a), .i_b(i_d), .o_p(ad));
    cfm_fmul u_mul_bc (.i_clk(i_clk), .i_en(i_en), .i_a(i_b), .i_b(i_c), .o_p(bc));

    assign neg_bd = {~bd[63], bd[62:0]};

    cfm_fadd u_add_re (.i_clk(i_clk), .i_en(i_en), .i_a(ac), .i_b(neg_bd), .o_s(o_real));
    cfm_fadd u_add_im (.i_clk(i_clk), .i_en(i_en), .i_a(ad), .i_b(bc), .o_s(o_imag));

    // An overflowed partial product is remembered alongside the sums.
    assign pp_inf = cfm_pkg::f_is_inf(ac) | cfm_pkg::f_is_inf(bd)
                  | cfm_pkg::f_is_inf(ad) | cfm_pkg::f_is_inf(bc);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_inf[0] <= pp_inf;
            for (int i = 1; i < cfm_pkg::ADD_LAT; i++) begin
                r_pp_inf[i] <= r_pp_inf[i-1];
            end
        end
    end

    assign o_pp_inf = r_pp_inf[cfm_pkg::ADD_LAT-1];

endmodule

`default_nettype wire

>>> sv/complex_float_multiply_unit.sv
// Top level of the pipelined binary64 complex multiplier with infinity recovery.
//
// Usage: one transaction on the input channel (i_in_valid / o_in_ready) carries
// two complex factors as four binary64 bit patterns. One transaction on the
// output channel (o_out_valid / i_out_ready) returns their product, real and
// imaginary parts, in the same order as the factors came in.
// Throughput is one transaction per cycle while no stall freezes the pipeline.
// The accepting edge loads the input register; eight multiplier stages, seven
// adder stages and the output register follow before o_out_valid rises.
// Two complex cores run side by side. The first computes the plain product.
// The second computes it from boxed factors (infinities to signed ones, other
// parts of that factor to signed zeros, NaNs to signed zeros). When both parts
// of the first result are NaN and an input was infinite or a partial product
// overflowed, the final stage takes the second result scaled by infinity.
// NaN results always leave as the canonical quiet NaN.
// Reset clears every valid bit; the datapath registers are not reset.
// When the receiver stalls, the output register holds its transaction and a
// skid register takes one more; only then does o_in_ready drop, and the whole
// pipeline freezes until the skid register drains.
`default_nettype none

module complex_float_multiply_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_left_real,
    input  logic [63:0] i_left_imag,
    input  logic [63:0] i_right_real,
    input  logic [63:0] i_right_imag,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_product_real,
    output logic [63:0] o_product_imag
);

    localparam int unsigned LAST = cfm_pkg::CORE_LAT - 1;

    logic        en;
    logic        r_s0_valid, n_s0_valid;
    logic [63:0] r_a, r_b, r_c, r_d;
    logic [63:0] box_a, box_b, box_c, box_d;
    logic        inf_left, inf_right;
    logic        r_vld [cfm_pkg::CORE_LAT];
    logic        r_any_inf [cfm_pkg::CORE_LAT];

    logic [63:0] x_main, y_main, x_redo, y_redo;
    logic        pp_inf_main;
    logic        redo, end_move, take;
    logic [63:0] res_real, res_imag;

    logic        r_out_valid, n_out_valid, r_skid_valid, n_skid_valid;
    logic [63:0] r_out_real, r_out_imag, n_out_real, n_out_imag;
    logic [63:0] r_skid_real, r_skid_imag, n_skid_real, n_skid_imag;

    // Boxing of one part: on the infinite side it becomes signed one or zero,
    // on the other side only a NaN is replaced by a signed zero.
    function automatic logic [63:0] f_box(input logic [63:0] v, input logic inf_side);
        logic [63:0] r;
        if (inf_side) begin
            r = {v[63], cfm_pkg::f_is_inf(v) ? cfm_pkg::ONE[62:0] : cfm_pkg::ZERO[62:0]};
        end else if (cfm_pkg::f_is_nan(v)) begin
            r = {v[63], cfm_pkg::ZERO[62:0]};
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Multiplication by plus infinity of a recomputed part.
    function automatic logic [63:0] f_scale_inf(input logic [63:0] v);
        logic [63:0] r;
        if (cfm_pkg::f_is_nan(v) || cfm_pkg::f_is_zero(v)) begin
            r = cfm_pkg::CANON_NAN;
        end else begin
            r = {v[63], cfm_pkg::POS_INF[62:0]};
        end
        return r;
    endfunction

    // The pipeline moves whenever the skid register is empty.
    assign en         = !r_skid_valid;
    assign o_in_ready = en;

    assign n_s0_valid = en ? i_in_valid : r_s0_valid;

    always_comb begin
        inf_left  = cfm_pkg::f_is_inf(r_a) | cfm_pkg::f_is_inf(r_b);
        inf_right = cfm_pkg::f_is_inf(r_c) | cfm_pkg::f_is_inf(r_d);
        box_a     = f_box(r_a, inf_left);
        box_b     = f_box(r_b, inf_left);
        box_c     = f_box(r_c, inf_right);
        box_d     = f_box(r_d, inf_right);
    end

    cfm_core u_core_main (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_a     (r_a),
        .i_b     (r_b),
        .i_c     (r_c),
        .i_d     (r_d),
        .o_real  (x_main),
        .o_imag  (y_main),
        .o_pp_inf(pp_inf_main)
    );

    cfm_core u_core_redo (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_a     (box_a),
        .i_b     (box_b),
        .i_c     (box_c),
        .i_d     (box_d),
        .o_real  (x_redo),
        .o_imag  (y_redo),
        .o_pp_inf()
    );

    // Final selection. The plain results already carry canonical NaNs.
    always_comb begin
        redo = cfm_pkg::f_is_nan(x_main) && cfm_pkg::f_is_nan(y_main)
            && (r_any_inf[LAST] || pp_inf_main);
        res_real = redo ? f_scale_inf(x_redo) : x_main;
        res_imag = redo ? f_scale_inf(y_redo) : y_main;
    end

    // Output register with one skid entry behind it.
    always_comb begin
        take         = r_out_valid && i_out_ready;
        end_move     = en && r_vld[LAST];
        n_out_valid  = r_out_valid;
        n_out_real   = r_out_real;
        n_out_imag   = r_out_imag;
        n_skid_valid = r_skid_valid;
        n_skid_real  = r_skid_real;
        n_skid_imag  = r_skid_imag;
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_real   = r_skid_real;
                n_out_imag   = r_skid_imag;
                n_skid_valid = 1'b0;
            end else if (end_move) begin
                n_out_valid = 1'b1;
                n_out_real  = res_real;
                n_out_imag  = res_imag;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (end_move) begin
            n_skid_valid = 1'b1;
            n_skid_real  = res_real;
            n_skid_imag  = res_imag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
            for (int i = 0; i < cfm_pkg::CORE_LAT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_s0_valid   <= n_s0_valid;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            if (en) begin
                r_vld[0] <= r_s0_valid;
                for (int i = 1; i < cfm_pkg::CORE_LAT; i++) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a          <= i_left_real;
            r_b          <= i_left_imag;
            r_c          <= i_right_real;
            r_d          <= i_right_imag;
            r_any_inf[0] <= inf_left | inf_right;
            for (int i = 1; i < cfm_pkg::CORE_LAT; i++) begin
                r_any_inf[i] <= r_any_inf[i-1];
            end
        end
        r_out_real  <= n_out_real;
        r_out_imag  <= n_out_imag;
        r_skid_real <= n_skid_real;
        r_skid_imag <= n_skid_imag;
    end

    assign o_out_valid    = r_out_valid;
    assign o_product_real = r_out_real;
    assign o_product_imag = r_out_imag;

endmodule

`default_nettype wire

>>> sv/cfm_checker.sv
// Port-level checks of the complex multiplier and their attachment to it.
`default_nettype none

module cfm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] o_product_real,
    input wire logic [63:0] o_product_imag
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    // Input side backs up only behind a waiting result.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

    // Reset leaves no result on the output.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Any NaN leaving the block is the canonical quiet NaN.
    a_nan_canon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_product_real[62:52] == 11'h7FF && o_product_real[51:0] != 52'd0)
                     || (o_product_imag[62:52] == 11'h7FF && o_product_imag[51:0] != 52'd0))
        |-> (o_product_real == cfm_pkg::CANON_NAN || o_product_real[62:52] != 11'h7FF
             || o_product_real[51:0] == 52'd0)
         && (o_product_imag == cfm_pkg::CANON_NAN || o_product_imag[62:52] != 11'h7FF
             || o_product_imag[51:0] == 52'd0))
        else $error("non-canonical NaN on output");

endmodule

bind complex_float_multiply_unit cfm_checker u_cfm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_product_real(o_product_real),
    .o_product_imag(o_product_imag)
);

`default_nettype wire
